// ===== src/sjpq_pkg.sv =====
// Shared types, widths and codes of the sorted job priority queue.
package sjpq_pkg;

    localparam int SJPQ_DEPTH    = 32;
    localparam int SIZE_W        = 16;
    localparam int PID_W         = 8;
    localparam int TIME_W        = 32;
    localparam int OCC_W         = 6;
    localparam int WAIT_W        = 48;
    localparam int JOBS_W        = 32;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [PID_W-1:0]  owner;
        logic [TIME_W-1:0] stamp;
    } t_job;

    typedef struct packed {
        logic ins;
        logic rem;
        t_job new_job;
    } t_cell_ctl;

endpackage

// ===== src/sjpq_if.sv =====
// Valid/ready channel interfaces for the queue's command and result beats.
interface sjpq_in_if;
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [sjpq_pkg::SIZE_W-1:0] job_size;
    logic [sjpq_pkg::PID_W-1:0]  process_id;
    logic [sjpq_pkg::TIME_W-1:0] now_time;

    modport source (output valid, opcode, job_size, process_id, now_time, input ready);
    modport sink   (input valid, opcode, job_size, process_id, now_time, output ready);
endinterface

interface sjpq_out_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic [sjpq_pkg::SIZE_W-1:0] out_job_size;
    logic [sjpq_pkg::PID_W-1:0]  out_process_id;
    logic [sjpq_pkg::OCC_W-1:0]  occupancy;
    logic [sjpq_pkg::WAIT_W-1:0] wait_total;
    logic [sjpq_pkg::JOBS_W-1:0] jobs_total;

    modport source (output valid, status, out_job_size, out_process_id, occupancy,
                    wait_total, jobs_total, input ready);
    modport sink   (input valid, status, out_job_size, out_process_id, occupancy,
                    wait_total, jobs_total, output ready);
endinterface

// ===== src/sjpq_cell.sv =====
// One slot of the sorted chain: holds a job and trades it with its neighbors.
module sjpq_cell (
    input  logic                i_clk,
    input  sjpq_pkg::t_cell_ctl i_ctl,
    input  logic                i_occupied,
    input  logic                i_left_keep,
    input  sjpq_pkg::t_job      i_left_job,
    input  sjpq_pkg::t_job      i_right_job,
    output logic                o_keep,
    output sjpq_pkg::t_job      o_job
);
    import sjpq_pkg::*;

    t_job r_job;
    t_job n_job;

    // A held job stays in place on insert when its size does not exceed the new one.
    assign o_keep = i_occupied && (r_job.size <= i_ctl.new_job.size);
    assign o_job  = r_job;

    always_comb begin
        n_job = r_job;
        if (i_ctl.ins) begin
            if (!o_keep) begin
                n_job = i_left_keep ? i_ctl.new_job : i_left_job;
            end
        end else if (i_ctl.rem) begin
            n_job = i_right_job;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

endmodule

// ===== src/sorted_job_priority_queue.sv =====
// Top level of the shortest-job-first queue built as a chain of sorted cells.
//
//  channel  dir  beat content                                         handshake
//  i_in     in   opcode, job_size, process_id, now_time               valid/ready
//  o_out    out  status, out_job_size, out_process_id, occupancy,     valid/ready
//                wait_total, jobs_total
//
// A new command beat can be accepted every clock while the command side is ready.
// All cells compare the new size at once and shift by one slot together, whatever the depth.
// The result appears in the output register in the cycle after the command beat.
// The command side is ready whenever the output register is empty or being taken.
// Synchronous reset empties the queue and clears both totals.
module sorted_job_priority_queue #(
    parameter int QUEUE_DEPTH = sjpq_pkg::SJPQ_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sjpq_in_if.sink     i_in,
    sjpq_out_if.source  o_out
);
    import sjpq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [WAIT_W-1:0] r_wait;
    logic [WAIT_W-1:0] n_wait;
    logic [JOBS_W-1:0] r_jobs;
    logic [JOBS_W-1:0] n_jobs;

    logic              r_out_valid;
    t_status           r_status;
    logic [SIZE_W-1:0] r_out_size;
    logic [PID_W-1:0]  r_out_pid;
    logic [OCC_W-1:0]  r_occ;

    logic              accept;
    logic              is_insert;
    logic              is_full;
    logic              is_empty;
    t_cell_ctl         ctl;
    t_status           status_now;
    logic [TIME_W-1:0] wait_now;
    logic [WAIT_W:0]   wait_sum;

    logic [QUEUE_DEPTH-1:0] keep;
    t_job                   jobs [QUEUE_DEPTH];

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign is_insert  = (i_in.opcode == OP_INSERT);
    assign is_full    = (r_count == CNT_W'(QUEUE_DEPTH));
    assign is_empty   = (r_count == '0);

    assign ctl.ins            = accept && is_insert && !is_full;
    assign ctl.rem            = accept && !is_insert && !is_empty;
    assign ctl.new_job.size   = i_in.job_size;
    assign ctl.new_job.owner  = i_in.process_id;
    assign ctl.new_job.stamp  = i_in.now_time;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic occ;
        logic left_keep;
        t_job left_job;
        t_job right_job;

        assign occ = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_first
            assign left_keep = 1'b1;
            assign left_job  = ctl.new_job;
        end else begin : g_inner
            assign left_keep = keep[g-1];
            assign left_job  = jobs[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign right_job = jobs[g];
        end else begin : g_body
            assign right_job = jobs[g+1];
        end

        sjpq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_occupied  (occ),
            .i_left_keep (left_keep),
            .i_left_job  (left_job),
            .i_right_job (right_job),
            .o_keep      (keep[g]),
            .o_job       (jobs[g])
        );
    end

    assign wait_now = i_in.now_time - jobs[0].stamp;
    assign wait_sum = {1'b0, r_wait} + (WAIT_W + 1)'(wait_now);

    always_comb begin
        n_count = r_count;
        n_wait  = r_wait;
        n_jobs  = r_jobs;
        if (ctl.ins) begin
            n_count = r_count + 1'b1;
            if (r_jobs != '1) begin
                n_jobs = r_jobs + 1'b1;
            end
        end
        if (ctl.rem) begin
            n_count = r_count - 1'b1;
            n_wait  = wait_sum[WAIT_W] ? '1 : wait_sum[WAIT_W-1:0];
        end
    end

    always_comb begin
        status_now = ST_DONE;
        if (is_insert && is_full) begin
            status_now = ST_FULL;
        end else if (!is_insert && is_empty) begin
            status_now = ST_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_wait      <= '0;
            r_jobs      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_wait  <= n_wait;
            r_jobs  <= n_jobs;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status   <= status_now;
            r_out_size <= ctl.rem ? jobs[0].size : '0;
            r_out_pid  <= ctl.rem ? jobs[0].owner : '0;
            r_occ      <= OCC_W'(n_count);
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_status;
    assign o_out.out_job_size   = r_out_size;
    assign o_out.out_process_id = r_out_pid;
    assign o_out.occupancy      = r_occ;
    assign o_out.wait_total     = r_wait;
    assign o_out.jobs_total     = r_jobs;

endmodule

// ===== src/sjpq_checker.sv =====
// Port-level assertions for the sorted job priority queue and their binding.
module sjpq_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [1:0]                  i_status,
    input logic [sjpq_pkg::SIZE_W-1:0] i_out_size,
    input logic [sjpq_pkg::PID_W-1:0]  i_out_pid,
    input logic [sjpq_pkg::OCC_W-1:0]  i_occupancy,
    input logic [sjpq_pkg::WAIT_W-1:0] i_wait_total
);
    import sjpq_pkg::*;

    // A result beat that waits is not withdrawn.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // Every command beat yields a result beat in the next cycle.
    a_cmd_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("command beat produced no result");

    // A rejected remove reports an empty queue and no job.
    a_empty_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == ST_EMPTY) |->
        (i_occupancy == '0 && i_out_size == '0 && i_out_pid == '0))
        else $error("empty rejection carries data");

    // A rejected insert carries no job.
    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == ST_FULL) |-> (i_out_size == '0 && i_out_pid == '0))
        else $error("full rejection carries data");

    // The wait total never goes down between result beats.
    a_wait_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && $past(i_out_valid)) |-> (i_wait_total >= $past(i_wait_total)))
        else $error("wait total decreased");

endmodule

bind sorted_job_priority_queue sjpq_checker u_sjpq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_status     (o_out.status),
    .i_out_size   (o_out.out_job_size),
    .i_out_pid    (o_out.out_process_id),
    .i_occupancy  (o_out.occupancy),
    .i_wait_total (o_out.wait_total)
);
